[rtl/assert_macros.svh]
// Assertion macros for the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define ASSERT_ON_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rvid_pkg.sv]
// Types, codes and lookup functions for the RV32I decoder
`timescale 1ns / 1ps

package rvid_pkg;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] CLS_ALU    = 3'd0;
  localparam logic [2:0] CLS_JUMP   = 3'd1;
  localparam logic [2:0] CLS_BRANCH = 3'd2;
  localparam logic [2:0] CLS_LOAD   = 3'd3;
  localparam logic [2:0] CLS_SB     = 3'd4;
  localparam logic [2:0] CLS_SH     = 3'd5;
  localparam logic [2:0] CLS_SW     = 3'd6;

  localparam logic [5:0] OP_LUI   = 6'd0;
  localparam logic [5:0] OP_AUIPC = 6'd1;
  localparam logic [5:0] OP_JAL   = 6'd2;
  localparam logic [5:0] OP_JALR  = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_BLT   = 6'd6;
  localparam logic [5:0] OP_BGE   = 6'd7;
  localparam logic [5:0] OP_BLTU  = 6'd8;
  localparam logic [5:0] OP_BGEU  = 6'd9;
  localparam logic [5:0] OP_LB    = 6'd10;
  localparam logic [5:0] OP_LH    = 6'd11;
  localparam logic [5:0] OP_LW    = 6'd12;
  localparam logic [5:0] OP_LBU   = 6'd13;
  localparam logic [5:0] OP_LHU   = 6'd14;
  localparam logic [5:0] OP_SB    = 6'd15;
  localparam logic [5:0] OP_SH    = 6'd16;
  localparam logic [5:0] OP_SW    = 6'd17;
  localparam logic [5:0] OP_ADDI  = 6'd18;
  localparam logic [5:0] OP_SLTI  = 6'd19;
  localparam logic [5:0] OP_SLTIU = 6'd20;
  localparam logic [5:0] OP_XORI  = 6'd21;
  localparam logic [5:0] OP_ORI   = 6'd22;
  localparam logic [5:0] OP_ANDI  = 6'd23;
  localparam logic [5:0] OP_SLLI  = 6'd24;
  localparam logic [5:0] OP_SRLI  = 6'd25;
  localparam logic [5:0] OP_SRAI  = 6'd26;
  localparam logic [5:0] OP_ADD   = 6'd27;
  localparam logic [5:0] OP_SUB   = 6'd28;
  localparam logic [5:0] OP_SLL   = 6'd29;
  localparam logic [5:0] OP_SLT   = 6'd30;
  localparam logic [5:0] OP_SLTU  = 6'd31;
  localparam logic [5:0] OP_XOR   = 6'd32;
  localparam logic [5:0] OP_SRL   = 6'd33;
  localparam logic [5:0] OP_SRA   = 6'd34;
  localparam logic [5:0] OP_OR    = 6'd35;
  localparam logic [5:0] OP_AND   = 6'd36;

  typedef enum logic [3:0] {
    KIND_LUI,
    KIND_AUIPC,
    KIND_JAL,
    KIND_JALR,
    KIND_BRANCH,
    KIND_LOAD,
    KIND_STORE,
    KIND_OPIMM,
    KIND_OP,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] op;
  } opsel_t;

  // first stage: opcode sorted into a format kind
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] word;
    logic [31:0] pc;
    logic [31:0] npc;
  } s1_t;

  // second stage: op resolved, immediate built, field usage known
  typedef struct packed {
    logic        valid;
    logic        bad;
    logic [2:0]  cls;
    logic [5:0]  op;
    logic        use_rd;
    logic        use_rs1;
    logic        use_rs2;
    logic        use_pc;
    logic        use_npc;
    logic [14:0] regs;   // {rs2, rs1, rd}
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] npc;
  } s2_t;

  // final record
  typedef struct packed {
    logic        valid;
    logic [2:0]  cls;
    logic [5:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] npc;
    logic        illegal;
  } s3_t;

  function automatic kind_t opcode_kind(input logic [6:0] opc);
    kind_t k;
    unique case (opc)
      OPC_LUI:    k = KIND_LUI;
      OPC_AUIPC:  k = KIND_AUIPC;
      OPC_JAL:    k = KIND_JAL;
      OPC_JALR:   k = KIND_JALR;
      OPC_BRANCH: k = KIND_BRANCH;
      OPC_LOAD:   k = KIND_LOAD;
      OPC_STORE:  k = KIND_STORE;
      OPC_OPIMM:  k = KIND_OPIMM;
      OPC_OP:     k = KIND_OP;
      default:    k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic opsel_t branch_op(input logic [2:0] f3);
    opsel_t s;
    unique case (f3)
      3'd0:    s = '{bad: 1'b0, op: OP_BEQ};
      3'd1:    s = '{bad: 1'b0, op: OP_BNE};
      3'd4:    s = '{bad: 1'b0, op: OP_BLT};
      3'd5:    s = '{bad: 1'b0, op: OP_BGE};
      3'd6:    s = '{bad: 1'b0, op: OP_BLTU};
      3'd7:    s = '{bad: 1'b0, op: OP_BGEU};
      default: s = '{bad: 1'b1, op: OP_LUI};
    endcase
    return s;
  endfunction

  function automatic opsel_t load_op(input logic [2:0] f3);
    opsel_t s;
    unique case (f3)
      3'd0:    s = '{bad: 1'b0, op: OP_LB};
      3'd1:    s = '{bad: 1'b0, op: OP_LH};
      3'd2:    s = '{bad: 1'b0, op: OP_LW};
      3'd4:    s = '{bad: 1'b0, op: OP_LBU};
      3'd5:    s = '{bad: 1'b0, op: OP_LHU};
      default: s = '{bad: 1'b1, op: OP_LUI};
    endcase
    return s;
  endfunction

  function automatic opsel_t opimm_op(input logic [2:0] f3, input logic [6:0] f7);
    opsel_t s;
    unique case (f3)
      3'd0: s = '{bad: 1'b0, op: OP_ADDI};
      3'd1: s = '{bad: 1'b0, op: OP_SLLI};
      3'd2: s = '{bad: 1'b0, op: OP_SLTI};
      3'd3: s = '{bad: 1'b0, op: OP_SLTIU};
      3'd4: s = '{bad: 1'b0, op: OP_XORI};
      3'd5: s = (f7 == F7_BASE) ? '{bad: 1'b0, op: OP_SRLI} :
                (f7 == F7_ALT)  ? '{bad: 1'b0, op: OP_SRAI} :
                                  '{bad: 1'b1, op: OP_LUI};
      3'd6: s = '{bad: 1'b0, op: OP_ORI};
      3'd7: s = '{bad: 1'b0, op: OP_ANDI};
    endcase
    return s;
  endfunction

  function automatic opsel_t reg_op(input logic [2:0] f3, input logic [6:0] f7);
    opsel_t s;
    unique case (f3)
      3'd0: s = (f7 == F7_BASE) ? '{bad: 1'b0, op: OP_ADD} :
                (f7 == F7_ALT)  ? '{bad: 1'b0, op: OP_SUB} :
                                  '{bad: 1'b1, op: OP_LUI};
      3'd1: s = '{bad: 1'b0, op: OP_SLL};
      3'd2: s = '{bad: 1'b0, op: OP_SLT};
      3'd3: s = '{bad: 1'b0, op: OP_SLTU};
      3'd4: s = '{bad: 1'b0, op: OP_XOR};
      3'd5: s = (f7 == F7_BASE) ? '{bad: 1'b0, op: OP_SRL} :
                (f7 == F7_ALT)  ? '{bad: 1'b0, op: OP_SRA} :
                                  '{bad: 1'b1, op: OP_LUI};
      3'd6: s = '{bad: 1'b0, op: OP_OR};
      3'd7: s = '{bad: 1'b0, op: OP_AND};
    endcase
    return s;
  endfunction

endpackage

[rtl/rvid_fetch_if.sv]
// Valid/ready channel carrying one fetched instruction slot
`timescale 1ns / 1ps

interface rvid_fetch_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [31:0] instruction_pc;
  logic [31:0] predicted_next_pc;

  modport source(output valid, output instruction, output instruction_pc,
                 output predicted_next_pc, input ready);
  modport sink(input valid, input instruction, input instruction_pc,
               input predicted_next_pc, output ready);
endinterface

[rtl/rvid_decoded_if.sv]
// Valid/ready channel carrying one decoded instruction record
`timescale 1ns / 1ps

interface rvid_decoded_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation_class;
  logic [5:0]  operation;
  logic [4:0]  dest_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  src2_reg;
  logic [31:0] immediate;
  logic [31:0] pc_out;
  logic [31:0] predicted_next_out;
  logic        illegal;

  modport source(output valid, output operation_class, output operation,
                 output dest_reg, output src1_reg, output src2_reg,
                 output immediate, output pc_out, output predicted_next_out,
                 output illegal, input ready);
  modport sink(input valid, input operation_class, input operation,
               input dest_reg, input src1_reg, input src2_reg,
               input immediate, input pc_out, input predicted_next_out,
               input illegal, output ready);
endinterface

[rtl/rvid_fetch_stage.sv]
// Stage 1: capture the slot, drop zero-word fetch bubbles, sort the opcode
`timescale 1ns / 1ps

module rvid_fetch_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   in_word,
  input  logic [31:0]   in_pc,
  input  logic [31:0]   in_npc,
  output logic          in_ready,
  output rvid_pkg::s1_t q,
  input  logic          q_ready
);

  rvid_pkg::s1_t stage;

  assign in_ready = !stage.valid || q_ready;
  assign q        = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_ready) begin
      // an all-zero word is a fetch bubble: taken but not passed on
      stage.valid <= in_valid && (in_word != '0);
    end
    if (in_ready && in_valid) begin
      stage.kind <= rvid_pkg::opcode_kind(in_word[6:0]);
      stage.word <= in_word;
      stage.pc   <= in_pc;
      stage.npc  <= in_npc;
    end
  end

endmodule

[rtl/rvid_decode_stage.sv]
// Stage 2: resolve the operation and legality, build the immediate
`timescale 1ns / 1ps

module rvid_decode_stage (
  input  logic          clk,
  input  logic          rst,
  input  rvid_pkg::s1_t d,
  output logic          d_ready,
  output rvid_pkg::s2_t q,
  input  logic          q_ready
);

  rvid_pkg::s2_t stage;
  rvid_pkg::s2_t stage_next;
  rvid_pkg::opsel_t sel;
  logic [31:0] w;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

  assign d_ready = !stage.valid || q_ready;
  assign q       = stage;

  assign w  = d.word;
  assign f3 = w[14:12];
  assign f7 = w[31:25];

  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u = {w[31:12], 12'h000};

  always_comb begin
    stage_next         = '0;
    stage_next.valid   = d.valid;
    stage_next.regs    = {w[24:20], w[19:15], w[11:7]};
    stage_next.pc      = d.pc;
    stage_next.npc     = d.npc;
    sel                = '{bad: 1'b0, op: rvid_pkg::OP_LUI};
    unique case (d.kind)
      rvid_pkg::KIND_LUI: begin
        sel.op            = rvid_pkg::OP_LUI;
        stage_next.use_rd = 1'b1;
        stage_next.imm    = imm_u;
      end
      rvid_pkg::KIND_AUIPC: begin
        sel.op            = rvid_pkg::OP_AUIPC;
        stage_next.use_rd = 1'b1;
        stage_next.use_pc = 1'b1;
        stage_next.imm    = imm_u;
      end
      rvid_pkg::KIND_JAL: begin
        sel.op             = rvid_pkg::OP_JAL;
        stage_next.cls     = rvid_pkg::CLS_JUMP;
        stage_next.use_rd  = 1'b1;
        stage_next.use_pc  = 1'b1;
        stage_next.use_npc = 1'b1;
        stage_next.imm     = imm_j;
      end
      rvid_pkg::KIND_JALR: begin
        sel.op             = rvid_pkg::OP_JALR;
        stage_next.cls     = rvid_pkg::CLS_JUMP;
        stage_next.use_rd  = 1'b1;
        stage_next.use_rs1 = 1'b1;
        stage_next.use_pc  = 1'b1;
        stage_next.use_npc = 1'b1;
        stage_next.imm     = imm_i;
      end
      rvid_pkg::KIND_BRANCH: begin
        sel                = rvid_pkg::branch_op(f3);
        stage_next.cls     = rvid_pkg::CLS_BRANCH;
        stage_next.use_rs1 = 1'b1;
        stage_next.use_rs2 = 1'b1;
        stage_next.use_pc  = 1'b1;
        stage_next.use_npc = 1'b1;
        stage_next.imm     = imm_b;
      end
      rvid_pkg::KIND_LOAD: begin
        sel                = rvid_pkg::load_op(f3);
        stage_next.cls     = rvid_pkg::CLS_LOAD;
        stage_next.use_rd  = 1'b1;
        stage_next.use_rs1 = 1'b1;
        stage_next.imm     = imm_i;
      end
      rvid_pkg::KIND_STORE: begin
        // byte, half, word map onto consecutive class and op codes
        sel.bad            = f3[2] || (f3[1:0] == 2'd3);
        sel.op             = rvid_pkg::OP_SB + {4'd0, f3[1:0]};
        stage_next.cls     = rvid_pkg::CLS_SB + {1'b0, f3[1:0]};
        stage_next.use_rs1 = 1'b1;
        stage_next.use_rs2 = 1'b1;
        stage_next.imm     = imm_s;
      end
      rvid_pkg::KIND_OPIMM: begin
        sel                = rvid_pkg::opimm_op(f3, f7);
        stage_next.use_rd  = 1'b1;
        stage_next.use_rs1 = 1'b1;
        // shift-immediates keep only the shift amount
        stage_next.imm     = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, w[24:20]} : imm_i;
      end
      rvid_pkg::KIND_OP: begin
        sel                = rvid_pkg::reg_op(f3, f7);
        stage_next.use_rd  = 1'b1;
        stage_next.use_rs1 = 1'b1;
        stage_next.use_rs2 = 1'b1;
      end
      rvid_pkg::KIND_BAD: begin
        sel.bad = 1'b1;
      end
      default: begin
        sel.bad = 1'b1;
      end
    endcase
    stage_next.bad = sel.bad;
    stage_next.op  = sel.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (d_ready) begin
      stage.valid <= d.valid;
    end
    if (d_ready && d.valid) begin
      stage.bad     <= stage_next.bad;
      stage.cls     <= stage_next.cls;
      stage.op      <= stage_next.op;
      stage.use_rd  <= stage_next.use_rd;
      stage.use_rs1 <= stage_next.use_rs1;
      stage.use_rs2 <= stage_next.use_rs2;
      stage.use_pc  <= stage_next.use_pc;
      stage.use_npc <= stage_next.use_npc;
      stage.regs    <= stage_next.regs;
      stage.imm     <= stage_next.imm;
      stage.pc      <= stage_next.pc;
      stage.npc     <= stage_next.npc;
    end
  end

endmodule

[rtl/rvid_pack_stage.sv]
// Stage 3: zero unused fields, clear illegal records, hold the result
`timescale 1ns / 1ps

module rvid_pack_stage (
  input  logic          clk,
  input  logic          rst,
  input  rvid_pkg::s2_t d,
  output logic          d_ready,
  output rvid_pkg::s3_t q,
  input  logic          q_ready
);

  rvid_pkg::s3_t stage;
  logic          ok;

  assign d_ready = !stage.valid || q_ready;
  assign q       = stage;
  assign ok      = !d.bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (d_ready) begin
      stage.valid <= d.valid;
    end
    if (d_ready && d.valid) begin
      stage.cls     <= ok ? d.cls : 3'd0;
      stage.op      <= ok ? d.op : 6'd0;
      stage.rd      <= (ok && d.use_rd) ? d.regs[4:0] : 5'd0;
      stage.rs1     <= (ok && d.use_rs1) ? d.regs[9:5] : 5'd0;
      stage.rs2     <= (ok && d.use_rs2) ? d.regs[14:10] : 5'd0;
      stage.imm     <= ok ? d.imm : 32'd0;
      stage.pc      <= (ok && d.use_pc) ? d.pc : 32'd0;
      stage.npc     <= (ok && d.use_npc) ? d.npc : 32'd0;
      stage.illegal <= d.bad;
    end
  end

endmodule

[rtl/rv32i_instruction_decoder_core.sv]
// RV32I decoder: three-stage valid/ready pipeline from fetch slot to decoded record
// Each instruction is registered in turn in the fetch, decode and pack stages.
// One instruction per cycle unless stalled; each stage frees when its successor takes.
// A zero instruction word is taken and dropped in the first stage, with no result.
// Synchronous reset clears the three stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rv32i_instruction_decoder_core (
  input  logic                  clk,
  input  logic                  rst,
  rvid_fetch_if.sink            fetch,
  rvid_decoded_if.source        decoded
);

  rvid_pkg::s1_t s1;
  rvid_pkg::s2_t s2;
  rvid_pkg::s3_t s3;
  logic          s1_ready;
  logic          s2_ready;

  rvid_fetch_stage u_fetch (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fetch.valid),
    .in_word  (fetch.instruction),
    .in_pc    (fetch.instruction_pc),
    .in_npc   (fetch.predicted_next_pc),
    .in_ready (fetch.ready),
    .q        (s1),
    .q_ready  (s1_ready)
  );

  rvid_decode_stage u_decode (
    .clk     (clk),
    .rst     (rst),
    .d       (s1),
    .d_ready (s1_ready),
    .q       (s2),
    .q_ready (s2_ready)
  );

  rvid_pack_stage u_pack (
    .clk     (clk),
    .rst     (rst),
    .d       (s2),
    .d_ready (s2_ready),
    .q       (s3),
    .q_ready (decoded.ready)
  );

  assign decoded.valid              = s3.valid;
  assign decoded.operation_class    = s3.cls;
  assign decoded.operation          = s3.op;
  assign decoded.dest_reg           = s3.rd;
  assign decoded.src1_reg           = s3.rs1;
  assign decoded.src2_reg           = s3.rs2;
  assign decoded.immediate          = s3.imm;
  assign decoded.pc_out             = s3.pc;
  assign decoded.predicted_next_out = s3.npc;
  assign decoded.illegal            = s3.illegal;

  `ASSERT_ON_RUN(a_bubble_dropped, clk, rst,
    fetch.valid && fetch.ready && (fetch.instruction == 32'd0) |=> !s1.valid,
    "zero instruction word entered the pipeline")
  `ASSERT_ON_RUN(a_illegal_clear, clk, rst,
    decoded.valid && decoded.illegal |-> (decoded.operation == rvid_pkg::OP_LUI) &&
      (decoded.immediate == 32'd0) && (decoded.pc_out == 32'd0) &&
      (decoded.dest_reg == 5'd0),
    "illegal record carries nonzero fields")
  `ASSERT_ON_RUN(a_pred_only_flow, clk, rst,
    decoded.valid && (decoded.predicted_next_out != 32'd0) |->
      (decoded.operation_class == rvid_pkg::CLS_JUMP) ||
      (decoded.operation_class == rvid_pkg::CLS_BRANCH),
    "prediction passed on for a non-flow instruction")
  `ASSERT_ON_RUN(a_op_range, clk, rst,
    decoded.valid && !decoded.illegal |-> (decoded.operation <= rvid_pkg::OP_AND),
    "operation code out of range")
  `ASSERT_ALWAYS(a_reset_empty, clk,
    rst |=> !decoded.valid && !s1.valid && !s2.valid,
    "pipeline not empty after reset")

endmodule
